// ----- hdl/owsm_pkg.sv -----
// Shared types, constants and helpers of the one-wire slot master.
package owsm_pkg;

  // Default number of bus lines in use
  localparam int unsigned LineCountDefault = 4;
  // Number of line bits carried on the channels
  localparam int unsigned LineBits = 4;
  // Tick counter width: the longest slot is 500 ticks
  localparam int unsigned TickW = 9;

  // Slot lengths in microsecond ticks
  localparam logic [TickW-1:0] RstLowLen  = TickW'(485);
  localparam logic [TickW-1:0] RstWaitLen = TickW'(65);
  localparam logic [TickW-1:0] RstRecLen  = TickW'(500);
  localparam logic [TickW-1:0] WrLongLen  = TickW'(65);
  localparam logic [TickW-1:0] WrShortLen = TickW'(3);
  localparam logic [TickW-1:0] WrGapLen   = TickW'(5);
  localparam logic [TickW-1:0] RdLowLen   = TickW'(2);
  localparam logic [TickW-1:0] RdWaitLen  = TickW'(13);
  localparam logic [TickW-1:0] RdRecLen   = TickW'(45);
  localparam logic [TickW-1:0] OtherLen   = TickW'(1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_WR_GAP   = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_REC   = 4'd9
  } phase_e;

  // One command or tick as taken from the input channel
  typedef struct packed {
    logic [1:0]          operation;
    logic [1:0]          line_select;
    logic [7:0]          data_byte;
    logic [LineBits-1:0] line_levels;
  } item_t;

  // One result item
  typedef struct packed {
    logic [LineBits-1:0] drive_low;
    logic                busy_res;
    logic                done_res;
    logic [7:0]          read_byte;
    logic [LineBits-1:0] presence_mask;
    logic                rejected;
  } result_t;

  // Mask of the lines in use
  function automatic logic [LineBits-1:0] line_mask(int unsigned count);
    logic [LineBits-1:0] m;
    for (int unsigned i = 0; i < LineBits; i++) begin
      m[i] = (i < count);
    end
    return m;
  endfunction

endpackage

// ----- hdl/owsm_if.sv -----
// Input and result channel interfaces of the one-wire slot master.
interface owsm_in_if;
  import owsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [1:0]          line_select;
  logic [7:0]          data_byte;
  logic [LineBits-1:0] line_levels;

  modport source (output valid, output operation, output line_select,
                  output data_byte, output line_levels, input ready);
  modport sink   (input valid, input operation, input line_select,
                  input data_byte, input line_levels, output ready);
endinterface

interface owsm_out_if;
  import owsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [LineBits-1:0] drive_low;
  logic                busy_res;
  logic                done_res;
  logic [7:0]          read_byte;
  logic [LineBits-1:0] presence_mask;
  logic                rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_byte, output presence_mask, output rejected,
                  input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input read_byte, input presence_mask, input rejected,
                  output ready);
endinterface

// ----- hdl/one_wire_slot_master_core.sv -----
// One-wire slot master for up to four lines, timed by tick items of one
// microsecond each. Every tick or command gives one result item; a new
// item is accepted in every cycle as long as the two-entry result buffer
// has room, so the sustained rate is one item per clock while results are
// taken. The sequencer state update is the only logic between the input
// and the result buffer, and each result is registered in that buffer
// before it is offered. Commands that arrive during a running reset,
// write or read are flagged as rejected and leave the sequence untouched.
module one_wire_slot_master_core
  import owsm_pkg::*;
#(
  parameter int unsigned LINE_COUNT = LineCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  owsm_in_if.sink    in_i,
  owsm_out_if.source out_o
);

  item_t   item;
  result_t result;
  result_t head;
  logic    accept;
  logic    buf_ready;

  // Take an item whenever the result buffer has room
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  assign item.operation   = in_i.operation;
  assign item.line_select = in_i.line_select;
  assign item.data_byte   = in_i.data_byte;
  assign item.line_levels = in_i.line_levels;

  owsm_seq #(
    .LINE_COUNT(LINE_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(accept),
    .item_i      (item),
    .result_o    (result)
  );

  owsm_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (result),
    .ready_o    (buf_ready),
    .valid_o    (out_o.valid),
    .pop_ready_i(out_o.ready),
    .data_o     (head)
  );

  // Drive result fields from the buffer head
  assign out_o.drive_low     = head.drive_low;
  assign out_o.busy_res      = head.busy_res;
  assign out_o.done_res      = head.done_res;
  assign out_o.read_byte     = head.read_byte;
  assign out_o.presence_mask = head.presence_mask;
  assign out_o.rejected      = head.rejected;

endmodule

// ----- hdl/owsm_seq.sv -----
// Slot sequencer: phase, tick counter and byte state, updated once per transfer.
module owsm_seq
  import owsm_pkg::*;
#(
  parameter int unsigned LINE_COUNT = LineCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam logic [LineBits-1:0] LineMask = line_mask(LINE_COUNT);
  localparam logic [3:0]          LineLimit = 4'(LINE_COUNT);

  phase_e              phase_q, phase_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic [1:0]          line_q, line_d;
  logic [LineBits-1:0] presence_q, presence_d;
  logic [7:0]          last_q, last_d;

  op_e                 op;
  logic [TickW-1:0]    tick_inc;
  logic [TickW-1:0]    slot_len;
  logic                cur_bit;
  logic                done;
  logic                rej;

  assign op       = op_e'(item_i.operation);
  assign cur_bit  = shift_q[bit_q];
  assign tick_inc = tick_q + TickW'(1);

  // Length of the running slot
  always_comb begin
    unique case (phase_q)
      PH_RST_LOW:  slot_len = RstLowLen;
      PH_RST_WAIT: slot_len = RstWaitLen;
      PH_RST_REC:  slot_len = RstRecLen;
      PH_WR_LOW:   slot_len = cur_bit ? WrShortLen : WrLongLen;
      PH_WR_HIGH:  slot_len = cur_bit ? WrLongLen : WrShortLen;
      PH_WR_GAP:   slot_len = WrGapLen;
      PH_RD_LOW:   slot_len = RdLowLen;
      PH_RD_WAIT:  slot_len = RdWaitLen;
      PH_RD_REC:   slot_len = RdRecLen;
      default:     slot_len = OtherLen;
    endcase
  end

  // Next state: advance on ticks, start sequences on commands
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    line_d     = line_q;
    presence_d = presence_q;
    last_d     = last_q;
    done       = 1'b0;
    rej        = 1'b0;
    if (item_valid_i) begin
      priority if (op == OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (tick_inc < slot_len) begin
            tick_d = tick_inc;
          end else begin
            tick_d = '0;
            unique case (phase_q)
              PH_RST_LOW:  phase_d = PH_RST_WAIT;
              PH_RST_WAIT: begin
                presence_d = ~item_i.line_levels & LineMask;
                phase_d    = PH_RST_REC;
              end
              PH_RST_REC: begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
              PH_WR_LOW:   phase_d = PH_WR_HIGH;
              PH_WR_HIGH:  phase_d = PH_WR_GAP;
              PH_WR_GAP: begin
                if (bit_q == 3'd7) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_q + 3'd1;
                  phase_d = PH_WR_LOW;
                end
              end
              PH_RD_LOW:   phase_d = PH_RD_WAIT;
              PH_RD_WAIT: begin
                shift_d        = shift_q;
                shift_d[bit_q] = shift_q[bit_q] | item_i.line_levels[line_q];
                phase_d        = PH_RD_REC;
              end
              PH_RD_REC: begin
                if (bit_q == 3'd7) begin
                  last_d  = shift_q;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_q + 3'd1;
                  phase_d = PH_RD_LOW;
                end
              end
              default:     phase_d = PH_IDLE;
            endcase
          end
        end
      end else if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else if (op == OP_RESET) begin
        phase_d = PH_RST_LOW;
        tick_d  = '0;
      end else if ({2'b00, item_i.line_select} >= LineLimit) begin
        rej = 1'b1;
      end else begin
        line_d = item_i.line_select;
        bit_d  = '0;
        tick_d = '0;
        if (op == OP_WRITE) begin
          shift_d = item_i.data_byte;
          phase_d = PH_WR_LOW;
        end else begin
          shift_d = '0;
          phase_d = PH_RD_LOW;
        end
      end
    end
  end

  // Result fields from the state after the transfer
  always_comb begin
    unique case (phase_d)
      PH_RST_LOW:            result_o.drive_low = LineMask;
      PH_WR_LOW, PH_RD_LOW:  result_o.drive_low = LineMask & (LineBits'(1) << line_d);
      default:               result_o.drive_low = '0;
    endcase
    result_o.busy_res      = (phase_d != PH_IDLE);
    result_o.done_res      = done;
    result_o.read_byte     = last_d;
    result_o.presence_mask = presence_d;
    result_o.rejected      = rej;
  end

  // Hold state between transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      line_q     <= '0;
      presence_q <= '0;
      last_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      line_q     <= line_d;
      presence_q <= presence_d;
      last_q     <= last_d;
    end
  end

endmodule

// ----- hdl/owsm_skid.sv -----
// Two-entry result buffer that lets the input side keep going while a result waits.
module owsm_skid
  import owsm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  logic    v0_q, v0_d, v1_q, v1_d;
  result_t d0_q, d0_d, d1_q, d1_d;
  logic    pop;

  assign ready_o = !v1_q;
  assign valid_o = v0_q;
  assign data_o  = d0_q;
  assign pop     = v0_q && pop_ready_i;

  // Shift the head out on a transfer, fill the first free entry on a push
  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    unique case ({push_i, pop})
      2'b01: begin
        d0_d = d1_q;
        v0_d = v1_q;
        v1_d = 1'b0;
      end
      2'b10: begin
        if (!v0_q) begin
          d0_d = data_i;
          v0_d = 1'b1;
        end else begin
          d1_d = data_i;
          v1_d = 1'b1;
        end
      end
      2'b11: begin
        if (v1_q) begin
          d0_d = d1_q;
          d1_d = data_i;
        end else begin
          d0_d = data_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

endmodule

// ----- hdl/owsm_checker.sv -----
// Port-level checks of the one-wire slot master, bound to the top level.
module owsm_checker
  import owsm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [LineBits-1:0] drive_low_i,
  input logic                busy_res_i,
  input logic                done_res_i,
  input logic                rejected_i
);

  // A stalled result keeps its lines
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_low_i))
    else $error("stalled result changed");

  // Lines are only pulled low inside a sequence
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> drive_low_i == '0)
    else $error("line driven while idle");

  // A finished sequence leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> !busy_res_i)
    else $error("done while still busy");

  // Only ticks finish sequences, only commands are rejected
  a_done_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(done_res_i && rejected_i))
    else $error("done and rejected together");

endmodule

bind one_wire_slot_master_core owsm_checker u_owsm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .drive_low_i(out_o.drive_low),
  .busy_res_i (out_o.busy_res),
  .done_res_i (out_o.done_res),
  .rejected_i (out_o.rejected)
);

// ----- tb/owsm_slot_checker.sv -----
// Checker for the one-wire slot master: watches both channels, predicts each result and compares.
module owsm_slot_checker
  import owsm_pkg::*;
#(
  parameter int unsigned LINE_COUNT = LineCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  owsm_in_if   in_i,
  owsm_out_if  out_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LineBits-1:0] UsedLines = (LINE_COUNT >= LineBits) ?
      {LineBits{1'b1}} : LineBits'((1 << LINE_COUNT) - 1);

  // Shadow copy of the bus master state
  phase_e              phase_q;
  logic [9:0]          tick_q;
  logic [2:0]          bit_q;
  logic [7:0]          shift_q;
  logic [1:0]          line_q;
  logic [LineBits-1:0] presence_q;
  logic [7:0]          last_read_q;

  result_t bus_result_q[$];
  int      mismatch_count;

  // Length in ticks of the current slot phase
  function automatic logic [9:0] slot_ticks();
    logic one_bit;
    one_bit = shift_q[bit_q];
    case (phase_q)
      PH_RST_LOW:  return 10'd485;
      PH_RST_WAIT: return 10'd65;
      PH_RST_REC:  return 10'd500;
      PH_WR_LOW:   return one_bit ? 10'd3 : 10'd65;
      PH_WR_HIGH:  return one_bit ? 10'd65 : 10'd3;
      PH_WR_GAP:   return 10'd5;
      PH_RD_LOW:   return 10'd2;
      PH_RD_WAIT:  return 10'd13;
      PH_RD_REC:   return 10'd45;
      default:     return 10'd1;
    endcase
  endfunction

  // Apply one tick or command to the shadow state and return the result it gives
  function automatic result_t advance_bus_master(item_t it);
    result_t r;
    logic    done;
    logic    rej;
    done = 1'b0;
    rej  = 1'b0;
    if (op_e'(it.operation) == OP_TICK) begin
      if (phase_q != PH_IDLE) begin
        tick_q = tick_q + 10'd1;
        if (tick_q >= slot_ticks()) begin
          tick_q = '0;
          case (phase_q)
            PH_RST_LOW:  phase_q = PH_RST_WAIT;
            PH_RST_WAIT: begin
              presence_q = ~it.line_levels & UsedLines;
              phase_q    = PH_RST_REC;
            end
            PH_RST_REC: begin
              phase_q = PH_IDLE;
              done    = 1'b1;
            end
            PH_WR_LOW:  phase_q = PH_WR_HIGH;
            PH_WR_HIGH: phase_q = PH_WR_GAP;
            PH_WR_GAP: begin
              if (bit_q == 3'd7) begin
                phase_q = PH_IDLE;
                done    = 1'b1;
              end else begin
                bit_q   = bit_q + 3'd1;
                phase_q = PH_WR_LOW;
              end
            end
            PH_RD_LOW:  phase_q = PH_RD_WAIT;
            PH_RD_WAIT: begin
              if (it.line_levels[line_q]) shift_q[bit_q] = 1'b1;
              phase_q = PH_RD_REC;
            end
            PH_RD_REC: begin
              if (bit_q == 3'd7) begin
                last_read_q = shift_q;
                phase_q     = PH_IDLE;
                done        = 1'b1;
              end else begin
                bit_q   = bit_q + 3'd1;
                phase_q = PH_RD_LOW;
              end
            end
            default: phase_q = PH_IDLE;
          endcase
        end
      end
    end else if (phase_q != PH_IDLE) begin
      rej = 1'b1;
    end else if (op_e'(it.operation) == OP_RESET) begin
      phase_q = PH_RST_LOW;
      tick_q  = '0;
    end else if (32'(it.line_select) >= LINE_COUNT) begin
      rej = 1'b1;
    end else begin
      line_q = it.line_select;
      bit_q  = '0;
      tick_q = '0;
      if (op_e'(it.operation) == OP_WRITE) begin
        shift_q = it.data_byte;
        phase_q = PH_WR_LOW;
      end else begin
        shift_q = '0;
        phase_q = PH_RD_LOW;
      end
    end

    case (phase_q)
      PH_RST_LOW:           r.drive_low = UsedLines;
      PH_WR_LOW, PH_RD_LOW: r.drive_low = (LineBits'(1) << line_q) & UsedLines;
      default:              r.drive_low = '0;
    endcase
    r.busy_res      = (phase_q != PH_IDLE);
    r.done_res      = done;
    r.read_byte     = last_read_q;
    r.presence_mask = presence_q;
    r.rejected      = rej;
    return r;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // Compare the result transfer first: it always belongs to an earlier input
  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t want;
    if (!rst_ni) begin
      phase_q        = PH_IDLE;
      tick_q         = '0;
      bit_q          = '0;
      shift_q        = '0;
      line_q         = '0;
      presence_q     = '0;
      last_read_q    = '0;
      mismatch_count = 0;
      bus_result_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (bus_result_q.size() == 0) begin
          $display("%0t: result with none expected, actual drive %0h busy %0b done %0b",
                   $time, out_i.drive_low, out_i.busy_res, out_i.done_res);
          mismatch_count++;
        end else begin
          want = bus_result_q.pop_front();
          check_field("drive_low", 32'(want.drive_low), 32'(out_i.drive_low));
          check_field("busy_res", 32'(want.busy_res), 32'(out_i.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(out_i.done_res));
          check_field("read_byte", 32'(want.read_byte), 32'(out_i.read_byte));
          check_field("presence_mask", 32'(want.presence_mask),
                      32'(out_i.presence_mask));
          check_field("rejected", 32'(want.rejected), 32'(out_i.rejected));
        end
      end
      if (in_i.valid && in_i.ready) begin
        it.operation   = in_i.operation;
        it.line_select = in_i.line_select;
        it.data_byte   = in_i.data_byte;
        it.line_levels = in_i.line_levels;
        bus_result_q.push_back(advance_bus_master(it));
      end
      errors_o  <= mismatch_count;
      pending_o <= bus_result_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the one-wire slot master testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
  import owsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 4000;
  localparam int DrainLimit  = 5000;
  localparam int ResetTicks  = 1050;
  localparam int WriteTicks  = 584;
  localparam int ReadTicks   = 480;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  logic hold_off_req;
  int   burst_left;
  int   idle_cycles;

  owsm_in_if  in_if ();
  owsm_out_if out_if ();

  one_wire_slot_master_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  owsm_slot_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_if),
    .out_i    (out_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one item, with a random gap at the end of each burst, and hold until transfer
  task automatic send_item(input op_e op, input logic [1:0] sel, input logic [7:0] data,
                           input logic [3:0] lv);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.line_select <= sel;
    in_if.data_byte   <= data;
    in_if.line_levels <= lv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)));
    end
  endtask

  // Stop offering until every predicted result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: rotate through ready patterns, with one long hold-off on request
  initial begin
    int rx_cycle;
    bit held;
    rx_cycle     = 0;
    held         = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        out_if.ready <= 1'b0;
        held = 1'b1;
        repeat (300) @(posedge clk_i);
      end else begin
        rx_cycle++;
        case (rx_cycle[7:6])
          2'd0:    out_if.ready <= 1'b1;
          2'd1:    out_if.ready <= 1'($urandom_range(0, 1));
          2'd2:    out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (rx_cycle[1:0] == 2'd0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing is transferred for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_TICK;
    in_if.line_select = '0;
    in_if.data_byte   = '0;
    in_if.line_levels = '0;
    hold_off_req      = 1'b0;
    burst_left        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks change nothing
    send_item(OP_TICK, 2'd0, 8'h00, 4'h0);
    send_item(OP_TICK, 2'd3, 8'hFF, 4'hF);
    // Read on the top line; every command while busy is rejected
    send_item(OP_READ, 2'd3, 8'h00, 4'h0);
    send_item(OP_RESET, 2'd3, 8'hFF, 4'hF);
    send_item(OP_WRITE, 2'd0, 8'hFF, 4'h0);
    send_item(OP_READ, 2'd1, 8'h00, 4'hF);
    run_ticks(ReadTicks);
    // Stop offering until every result is back
    drain_results();

    // Write a random byte through a long receiver hold-off
    hold_off_req <= 1'b1;
    send_item(OP_WRITE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 4'h0);
    run_ticks(WriteTicks);

    // Reset and presence detect, with stray commands along the way
    send_item(OP_RESET, 2'd0, 8'h00, 4'h0);
    for (int i = 0; i < ResetTicks; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_item(op_e'($urandom_range(1, 3)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end
      run_ticks(1);
    end

    // Wait for the last results, then report the verdict
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < DrainLimit && pending != 0; w++) @(posedge clk_i);
    if (pending != 0) begin
      $display("Verification failed");
    end else begin
      repeat (8) @(posedge clk_i);
      if (errors == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
